@@ hw/rtl/bitmap_block_allocator_core_assert.svh @@
// Assertion macros for the bitmap block allocator checker.
// Each use samples on the rising edge of clk and is off during rst.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// plain property check
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
  `BBA_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
  `BBA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers of the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int BM_BYTES   = 64;
  localparam int BM_IDX_W   = (BM_BYTES > 1) ? $clog2(BM_BYTES) : 1;
  localparam int BM_CNT_W   = $clog2(BM_BYTES + 1);
  localparam int BLK_W      = 10;
  localparam int BLK_MAX    = (1 << BLK_W) - 1;
  localparam int CAND_W     = $clog2(BLK_MAX + BM_BYTES * 8 + 1);
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_BLOCK = 1'b1;

  typedef enum logic [1:0] {
    KIND_FIND = 2'd0,
    KIND_SET  = 2'd1,
    KIND_CLR  = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NOFREE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RES_OK,
    RES_RANGE,
    RES_NOFREE,
    RES_FIND
  } res_sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MARK_CHK,
    S_MARK_WR
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic     capture;   // latch input item, restart scan
    logic     scan_rd;   // read byte at scan counter, advance
    logic     mark_rd;   // read byte holding the marked block
    logic     mark_wr;   // write back modified byte
    logic     res_load;  // load result registers, strobe done
    res_sel_t res_sel;
  } bba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic range_err;  // latched block fails range check
    logic rd_pend;    // scan byte returned this cycle
    logic byte_hit;   // returned byte has a free bit
    logic rd_last;    // returned byte is the last one
    logic scan_end;   // every byte has been requested
  } bba_sts_t;

  // position of the first zero bit, MSB first
  function automatic logic [2:0] first_zero_msb(input logic [7:0] b);
    logic [2:0] pos;
    logic       hit;
    pos = '0;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!hit && !b[7-i]) begin
        pos = 3'(i);
        hit = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for find scans and mark read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        kind,
  input  wire bba_pkg::bba_sts_t sts,
  output bba_pkg::bba_cmd_t      cmd,
  output logic                   busy
);
  import bba_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.res_sel = RES_OK;
    busy        = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          unique case (kind_t'(kind))
            KIND_FIND: state_next = S_SCAN;
            KIND_SET,
            KIND_CLR:  state_next = S_MARK_CHK;
            KIND_NOP: begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        priority if (sts.rd_pend && sts.byte_hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_FIND;
          state_next   = S_IDLE;
        end else if (sts.rd_pend && sts.rd_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_NOFREE;
          state_next   = S_IDLE;
        end else begin
          cmd.scan_rd = !sts.scan_end;
        end
      end
      S_MARK_CHK: begin
        if (sts.range_err) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_RANGE;
          state_next   = S_IDLE;
        end else begin
          cmd.mark_rd = 1'b1;
          state_next  = S_MARK_WR;
        end
      end
      S_MARK_WR: begin
        cmd.mark_wr  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_OK;
        state_next   = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/bba_dpath.sv @@
// ----------------------------------------------------------------------------
// bba_dpath
// Bitmap memory, scan counter, range check, config and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dpath (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire bba_pkg::bba_cmd_t                      cmd,
  output bba_pkg::bba_sts_t                           sts,
  input  wire logic [1:0]                             kind,
  input  wire logic [bba_pkg::BLK_W-1:0]              block_number,
  input  wire logic                                   cfg_we,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [bba_pkg::BLK_W-1:0]              cfg_wdata,
  output logic                                        done,
  output logic [bba_pkg::BLK_W-1:0]                   found_block,
  output logic [1:0]                                  status
);
  import bba_pkg::*;

  logic [7:0]          mem [BM_BYTES];
  logic [BM_BYTES-1:0] vld;

  logic [BLK_W-1:0]    first_blk;
  logic [BLK_W-1:0]    last_blk;
  logic [1:0]          kind_q;
  logic [BLK_W-1:0]    blk_q;

  logic [BM_CNT_W-1:0] scan_cnt;
  logic [BM_IDX_W-1:0] rd_idx;
  logic                rd_pend;
  logic [7:0]          rd_data;
  logic                rd_vld;

  logic [BLK_W-1:0]    offset;
  logic [BM_IDX_W-1:0] mark_idx;
  logic [BM_IDX_W-1:0] raddr;
  logic                rd_en;
  logic [7:0]          rd_byte;
  logic [7:0]          bit_mask;
  logic [7:0]          wr_byte;
  logic [CAND_W-1:0]   cand;
  logic                cand_ok;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_blk <= '0;
      last_blk  <= BLK_W'(511);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_DATA: first_blk <= cfg_wdata;
        CFG_LAST_BLOCK: last_blk  <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      blk_q  <= block_number;
    end
  end

  // range check of the marked block
  assign offset   = blk_q - first_blk;
  assign mark_idx = offset[3 +: BM_IDX_W];
  assign sts.range_err = (blk_q < first_blk) || (blk_q > last_blk) ||
                         ({1'b0, offset[BLK_W-1:3]} >= 8'(BM_BYTES));

  // scan counter and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_rd;
      if (cmd.capture) begin
        scan_cnt <= '0;
      end else if (cmd.scan_rd) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_idx <= scan_cnt[BM_IDX_W-1:0];
    end
  end

  assign raddr = cmd.mark_rd ? mark_idx : scan_cnt[BM_IDX_W-1:0];
  assign rd_en = cmd.mark_rd || cmd.scan_rd;

  // bitmap memory; a byte never written reads as all free
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[raddr];
      rd_vld  <= vld[raddr];
    end
    if (cmd.mark_wr) begin
      mem[mark_idx] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.mark_wr) begin
      vld[mark_idx] <= 1'b1;
    end
  end

  assign rd_byte  = rd_vld ? rd_data : 8'h00;
  assign bit_mask = 8'h80 >> offset[2:0];
  assign wr_byte  = (kind_q == KIND_SET) ? (rd_byte | bit_mask) : (rd_byte & ~bit_mask);

  assign sts.rd_pend  = rd_pend;
  assign sts.byte_hit = (rd_byte != 8'hff);
  assign sts.rd_last  = (rd_idx == BM_IDX_W'(BM_BYTES - 1));
  assign sts.scan_end = (scan_cnt == BM_CNT_W'(BM_BYTES));

  // candidate block of the first free bit in the returned byte
  assign cand    = CAND_W'(first_blk) + CAND_W'({rd_idx, 3'b000}) +
                   CAND_W'(first_zero_msb(rd_byte));
  assign cand_ok = (cand <= CAND_W'(last_blk)) && (cand <= CAND_W'(BLK_MAX));

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_OK: begin
          found_block <= '0;
          status      <= ST_OK;
        end
        RES_RANGE: begin
          found_block <= '0;
          status      <= ST_RANGE;
        end
        RES_NOFREE: begin
          found_block <= '0;
          status      <= ST_NOFREE;
        end
        RES_FIND: begin
          if (cand_ok) begin
            found_block <= cand[BLK_W-1:0];
            status      <= ST_OK;
          end else begin
            found_block <= '0;
            status      <= ST_NOFREE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// Busy bitmap of storage blocks: find lowest free block, mark busy or free.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   kind, block_number                      start & !busy
//  result    found_block, status                     done, one cycle
//  config    cfg_index, cfg_wdata                    cfg_we
//
//  Find: the bitmap memory is scanned one byte per cycle through its
//  single registered read port until a byte with a free bit returns.
//  Mark: done after the range check when out of range, else after a read and a write.
//  Unused kind: done in the cycle after accept.
//  Reset clears all valid bits at once; no clearing pass is needed.
//  Results cannot be stalled; busy drops in the cycle done is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        kind,
  input  wire logic [bba_pkg::BLK_W-1:0]         block_number,
  output logic                                   done,
  output logic [bba_pkg::BLK_W-1:0]              found_block,
  output logic [1:0]                             status,
  input  wire logic                              cfg_we,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bba_pkg::BLK_W-1:0]         cfg_wdata
);
  import bba_pkg::*;

  bba_cmd_t cmd;
  bba_sts_t sts;

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bba_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .block_number (block_number),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .found_block  (found_block),
    .status       (status)
  );

endmodule

`default_nettype wire

@@ hw/rtl/bba_checker.sv @@
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_block_allocator_core_assert.svh"

module bba_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [1:0]                    kind,
  input wire logic                          done,
  input wire logic [bba_pkg::BLK_W-1:0]     found_block,
  input wire logic [1:0]                    status
);
  import bba_pkg::*;

  logic req_acc;
  logic nop_acc;
  logic nop_ok;
  logic err_ok;

  assign req_acc = start && !busy;
  // an unused kind answers in the next cycle without raising busy
  assign nop_acc = req_acc && (kind == KIND_NOP);
  assign nop_ok  = done && (status == ST_OK) && (found_block == '0);
  assign err_ok  = (found_block == '0) && (status != 2'd3);

  `BBA_ASSERT_IMP(a_done_idle, done, !busy, "result shown while busy")
  `BBA_ASSERT_NXT(a_busy_after_accept, req_acc && !nop_acc, busy, "not busy after accept")
  `BBA_ASSERT_NXT(a_nop_result, nop_acc, nop_ok, "unused kind result wrong")
  `BBA_ASSERT_IMP(a_err_zero, done && (status != ST_OK), err_ok, "bad error result")
  `BBA_ASSERT_NXT(a_done_single, done && !nop_acc, !done, "done longer than one cycle")

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .kind        (kind),
  .done        (done),
  .found_block (found_block),
  .status      (status)
);

`default_nettype wire

@@ tb/bitmap_block_allocator_core_tb.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core_tb
// Self-checking bench for the bitmap block allocator. A directed table covers
// reset state, range limits and unused kinds. Register sweeps then fill and
// empty the bitmap. Random phases under varied block windows follow. Each
// result is checked against a typed answer or a shadow bitmap kept in the bench.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int GAP_MAX     = 12;
  localparam int WDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES = BM_BYTES + 8;
  localparam int N_DIR       = 23;
  localparam int PHASE_ITEMS = 35;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    status_t          st;
  } answer_t;

  typedef struct packed {
    kind_t            k;
    logic [BLK_W-1:0] blk;
    logic             typed;
    answer_t          ans;
  } dir_row_t;

  // rows with typed = 1 carry their own answer, the rest use the shadow bitmap
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{KIND_FIND, 10'd0,    1'b1, '{10'd0, ST_OK}},
    '{KIND_FIND, 10'd1023, 1'b1, '{10'd0, ST_OK}},
    '{KIND_SET,  10'd0,    1'b1, '{10'd0, ST_OK}},
    '{KIND_FIND, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{KIND_SET,  10'd1023, 1'b1, '{10'd0, ST_RANGE}},
    '{KIND_CLR,  10'd1023, 1'b1, '{10'd0, ST_RANGE}},
    '{KIND_SET,  10'd512,  1'b1, '{10'd0, ST_RANGE}},
    '{KIND_SET,  10'd511,  1'b1, '{10'd0, ST_OK}},
    '{KIND_NOP,  10'd1023, 1'b1, '{10'd0, ST_OK}},
    '{KIND_NOP,  10'd0,    1'b1, '{10'd0, ST_OK}},
    '{KIND_SET,  10'd1,    1'b0, '{10'd0, ST_OK}},
    '{KIND_SET,  10'd2,    1'b0, '{10'd0, ST_OK}},
    '{KIND_SET,  10'd3,    1'b0, '{10'd0, ST_OK}},
    '{KIND_SET,  10'd4,    1'b0, '{10'd0, ST_OK}},
    '{KIND_SET,  10'd5,    1'b0, '{10'd0, ST_OK}},
    '{KIND_SET,  10'd6,    1'b0, '{10'd0, ST_OK}},
    '{KIND_SET,  10'd7,    1'b0, '{10'd0, ST_OK}},
    '{KIND_FIND, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{KIND_CLR,  10'd3,    1'b0, '{10'd0, ST_OK}},
    '{KIND_FIND, 10'd0,    1'b0, '{10'd0, ST_OK}},
    '{KIND_CLR,  10'd0,    1'b0, '{10'd0, ST_OK}},
    '{KIND_CLR,  10'd511,  1'b0, '{10'd0, ST_OK}},
    '{KIND_FIND, 10'd0,    1'b0, '{10'd0, ST_OK}}
  };

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 start        = 1'b0;
  logic [1:0]           kind         = KIND_FIND;
  logic [BLK_W-1:0]     block_number = '0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_FIRST_DATA;
  logic [BLK_W-1:0]     cfg_wdata    = '0;
  logic                 busy;
  logic                 done;
  logic [BLK_W-1:0]     found_block;
  logic [1:0]           status;

  // shadow state
  logic [7:0]       busy_map [BM_BYTES];
  logic [BLK_W-1:0] first_blk = '0;
  logic [BLK_W-1:0] last_blk  = 10'd511;
  answer_t          expected_answers [$];
  int               mismatch_cnt = 0;
  int               idle_cycles  = 0;
  bit               no_gaps      = 1'b0;

  bitmap_block_allocator_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .block_number (block_number),
    .done         (done),
    .found_block  (found_block),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < 200) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // lowest free block for a find, bit update for a mark
  task automatic bitmap_predict(input kind_t k, input logic [BLK_W-1:0] blk,
                                output answer_t ans);
    int  cand;
    int  offs;
    int  pos;
    bit  hit;
    ans.blk = '0;
    ans.st  = ST_OK;
    case (k)
      KIND_FIND: begin
        ans.st = ST_NOFREE;
        hit = 1'b0;
        for (int bi = 0; bi < BM_BYTES && !hit; bi++) begin
          if (busy_map[bi] != 8'hff) begin
            hit = 1'b1;
            pos = 0;
            while (pos < 8 && busy_map[bi][7-pos]) pos++;
            cand = int'(first_blk) + bi * 8 + pos;
            // free bit past the last block counts as none free
            if (cand <= int'(last_blk) && cand <= BLK_MAX) begin
              ans.blk = cand[BLK_W-1:0];
              ans.st  = ST_OK;
            end
          end
        end
      end
      KIND_SET, KIND_CLR: begin
        offs = int'(blk) - int'(first_blk);
        if (blk < first_blk || blk > last_blk || (offs >> 3) >= BM_BYTES)
          ans.st = ST_RANGE;
        else
          busy_map[offs >> 3][7 - (offs & 7)] = (k == KIND_SET);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input kind_t k, input logic [BLK_W-1:0] blk,
                           input logic typed, input answer_t typed_ans);
    int      gap;
    answer_t ans;
    gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    kind         <= k;
    block_number <= blk;
    // busy is stable at the falling edge; acceptance is the next rising edge
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    bitmap_predict(k, blk, ans);
    expected_answers.push_back(typed ? typed_ans : ans);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic [BLK_W-1:0] f, input logic [BLK_W-1:0] l);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_DATA;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_index <= CFG_LAST_BLOCK;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_we    <= 1'b0;
    first_blk = f;
    last_blk  = l;
  endtask

  // mostly in-window marks, biased to the low end so finds run deep
  task automatic random_item(input int lo, input int hi, input bit ordered);
    int               r;
    kind_t            k;
    logic [BLK_W-1:0] b;
    r = $urandom_range(0, 99);
    k = (r < 30) ? KIND_FIND : (r < 70) ? KIND_SET : (r < 90) ? KIND_CLR : KIND_NOP;
    r = $urandom_range(0, 99);
    if (!ordered || r < 15)
      b = BLK_W'($urandom);
    else if (r < 55)
      b = BLK_W'($urandom_range(lo, (hi - lo > 63) ? lo + 63 : hi));
    else
      b = BLK_W'($urandom_range(lo, hi));
    send_item(k, b, 1'b0, '0);
  endtask

  task automatic run_phase(input logic [BLK_W-1:0] f, input logic [BLK_W-1:0] l,
                           input int n, input kind_t sweep_kind);
    int top;
    top = int'(f) + BM_BYTES * 8 - 1;
    if (int'(l) < top) top = int'(l);
    write_config(f, l);
    no_gaps = ($urandom_range(0, 3) == 0);
    if ((sweep_kind == KIND_SET || sweep_kind == KIND_CLR) && f <= l) begin
      for (int b = int'(f); b <= top; b++) send_item(sweep_kind, BLK_W'(b), 1'b0, '0);
      send_item(KIND_FIND, BLK_W'($urandom), 1'b0, '0);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      if ($urandom_range(0, 29) == 0) drain_results();
      random_item(int'(f), top, f <= l);
    end
  endtask

  always @(negedge clk) begin : result_check
    answer_t want;
    if (!rst) begin
      if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (expected_answers.size() == 0) begin
          report_mismatch($sformatf("unexpected result block %0d status %0d",
                                    found_block, status));
        end else begin
          want = expected_answers.pop_front();
          if (found_block !== want.blk)
            report_mismatch($sformatf("found_block %0d, expected %0d",
                                      found_block, want.blk));
          if (status !== want.st)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
        end
      end
    end
  end

  initial begin
    wait (idle_cycles >= WDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [BLK_W-1:0] f_rand;
    logic [BLK_W-1:0] l_rand;
    foreach (busy_map[i]) busy_map[i] = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_item(DIR_TAB[i].k, DIR_TAB[i].blk, DIR_TAB[i].typed, DIR_TAB[i].ans);

    run_phase(10'd0,    10'd511,  PHASE_ITEMS, KIND_SET);  // bitmap full
    run_phase(10'd0,    10'd1023, PHASE_ITEMS, KIND_CLR);
    run_phase(10'd1000, 10'd1023, PHASE_ITEMS, KIND_SET);  // free bit past 1023
    run_phase(10'd0,    10'd5,    PHASE_ITEMS, KIND_NOP);  // free bit past last
    run_phase(10'd600,  10'd100,  PHASE_ITEMS, KIND_NOP);  // inverted window
    run_phase(10'd1023, 10'd1023, PHASE_ITEMS, KIND_NOP);
    run_phase(10'd0,    10'd0,    PHASE_ITEMS, KIND_NOP);
    run_phase(10'd512,  10'd1023, PHASE_ITEMS, KIND_NOP);
    repeat (6) begin
      f_rand = BLK_W'($urandom_range(0, 700));
      l_rand = ($urandom_range(0, 7) == 0) ? BLK_W'($urandom)
                                           : BLK_W'($urandom_range(f_rand, BLK_MAX));
      run_phase(f_rand, l_rand, PHASE_ITEMS, KIND_NOP);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_answers.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_dpath.sv
hw/rtl/bitmap_block_allocator_core.sv
hw/rtl/bba_checker.sv
tb/bitmap_block_allocator_core_tb.sv
